FILE: rtl/core/bsbo_pkg.sv
package bsbo_pkg;

  // Largest frame side supported by default.
  localparam int MAX_SIDE_DEFAULT = 256;

  // Width of each configuration register.
  localparam int CFG_W = 9;

  // Pixel layout inside the packed RGB word: red [7:0], green [15:8], blue [23:16].
  localparam int CHAN_W = 8;
  localparam int PIX_W  = 3 * CHAN_W;

  // Sum of three squared 8-bit channel differences, and the squared threshold.
  localparam int SQ_W   = 2 * CHAN_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int TSQ_W  = 2 * CFG_W;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register reset values.
  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 9'd256;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 9'd256;
  localparam logic [CFG_W-1:0] RST_THRESHOLD    = 9'd30;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESHOLD    = 2'd2;
  localparam int         APB_ADDR_W       = 4;
  localparam int         APB_DATA_W       = 32;

  // Item kinds carried by the opcode bit.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Stored pixel for background, and the box edge color.
  localparam logic [PIX_W-1:0] PIX_WHITE = 24'hFFFFFF;
  localparam logic [PIX_W-1:0] PIX_RED   = 24'h0000FF;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [CFG_W-1:0] frame_width;
    logic [CFG_W-1:0] frame_height;
    logic [CFG_W-1:0] distance_threshold;
  } cfg_t;

endpackage

FILE: rtl/core/bsbo_front.sv
module bsbo_front #(
  parameter int MAX_SIDE = bsbo_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bsbo_pkg::cfg_t              cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        in_op_i,
  // bg_red, bg_green, bg_blue, fg_red, fg_green, fg_blue from bit 0 up
  input  logic [6*bsbo_pkg::CHAN_W-1:0] in_data_i,
  input  logic [bsbo_pkg::QCNT_W-1:0] q_count_i,
  output logic                        q_push_o,
  output logic [3+2*$clog2(MAX_SIDE)+bsbo_pkg::PIX_W-1:0] q_data_o
);

  localparam int CW   = $clog2(MAX_SIDE);
  localparam int SW   = $clog2(MAX_SIDE + 1);
  localparam int CMPW = (SW > bsbo_pkg::CFG_W) ? SW : bsbo_pkg::CFG_W;
  localparam int CH   = bsbo_pkg::CHAN_W;

  logic [SW-1:0] side_w, side_h;
  logic          accept;

  // Raster positions of the load and the read streams.
  logic [CW-1:0] ld_row_q, ld_row_d, ld_col_q, ld_col_d;
  logic [CW-1:0] rd_row_q, rd_row_d, rd_col_q, rd_col_d;
  logic [CW-1:0] cur_row, cur_col, nxt_row, nxt_col;
  logic [SW-1:0] col_inc, row_inc;
  logic          cur_last;

  // Stage one of the front: squared differences and position.
  logic                     s1_valid_q;
  logic                     s1_op_q;
  logic                     s1_last_q;
  logic [CW-1:0]            s1_row_q, s1_col_q;
  logic [bsbo_pkg::PIX_W-1:0] s1_pix_q;
  logic [bsbo_pkg::SQ_W-1:0]  s1_sq_q [3];
  logic [bsbo_pkg::TSQ_W-1:0] thr_sq_q;
  logic [bsbo_pkg::SQ_W-1:0]  sq [3];
  logic [bsbo_pkg::SUM_W-1:0] sum;
  logic                       is_fg;
  logic [bsbo_pkg::PIX_W-1:0] store_pix;

  // Clamp a side register to the range one to MAX_SIDE.
  function automatic logic [SW-1:0] eff_side(input logic [bsbo_pkg::CFG_W-1:0] v);
    logic [CMPW-1:0] ve;
    ve = CMPW'(v);
    if (ve == '0) begin
      return SW'(1);
    end else if (ve > CMPW'(MAX_SIDE)) begin
      return SW'(MAX_SIDE);
    end
    return SW'(ve);
  endfunction

  assign side_w = eff_side(cfg_i.frame_width);
  assign side_h = eff_side(cfg_i.frame_height);

  // Space in the queue is reserved for the item held in stage one.
  assign in_ready_o = (q_count_i + bsbo_pkg::QCNT_W'(s1_valid_q))
                      < bsbo_pkg::QCNT_W'(bsbo_pkg::QUEUE_DEPTH);
  assign accept     = in_valid_i && in_ready_o;

  // Position of the accepted item and the one after it.
  always_comb begin
    cur_row = (in_op_i == bsbo_pkg::OP_READ) ? rd_row_q : ld_row_q;
    cur_col = (in_op_i == bsbo_pkg::OP_READ) ? rd_col_q : ld_col_q;
    col_inc = SW'(cur_col) + SW'(1);
    row_inc = SW'(cur_row) + SW'(1);
    cur_last = (row_inc == side_h) && (col_inc == side_w);
    nxt_col = cur_col;
    nxt_row = cur_row;
    if (col_inc >= side_w) begin
      nxt_col = '0;
      nxt_row = (row_inc >= side_h) ? '0 : CW'(row_inc);
    end else begin
      nxt_col = CW'(col_inc);
    end
  end

  always_comb begin
    ld_row_d = ld_row_q;
    ld_col_d = ld_col_q;
    rd_row_d = rd_row_q;
    rd_col_d = rd_col_q;
    if (accept) begin
      if (in_op_i == bsbo_pkg::OP_READ) begin
        rd_row_d = nxt_row;
        rd_col_d = nxt_col;
      end else begin
        ld_row_d = nxt_row;
        ld_col_d = nxt_col;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_row_q   <= '0;
      ld_col_q   <= '0;
      rd_row_q   <= '0;
      rd_col_q   <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      ld_row_q   <= ld_row_d;
      ld_col_q   <= ld_col_d;
      rd_row_q   <= rd_row_d;
      rd_col_q   <= rd_col_d;
      s1_valid_q <= accept;
    end
  end

  // Absolute channel differences, squared.
  always_comb begin
    logic [CH-1:0] a, b, d;
    for (int i = 0; i < 3; i++) begin
      a = in_data_i[i*CH +: CH];
      b = in_data_i[(i+3)*CH +: CH];
      d = (a > b) ? (a - b) : (b - a);
      sq[i] = bsbo_pkg::SQ_W'(d) * bsbo_pkg::SQ_W'(d);
    end
  end

  // Payload of stage one, and the squared threshold.
  always_ff @(posedge clk_i) begin
    thr_sq_q <= bsbo_pkg::TSQ_W'(cfg_i.distance_threshold)
              * bsbo_pkg::TSQ_W'(cfg_i.distance_threshold);
    if (accept) begin
      s1_op_q   <= in_op_i;
      s1_last_q <= cur_last;
      s1_row_q  <= cur_row;
      s1_col_q  <= cur_col;
      s1_pix_q  <= in_data_i[3*CH +: bsbo_pkg::PIX_W];
      s1_sq_q   <= sq;
    end
  end

  // Foreground test and the pixel to store.
  always_comb begin
    sum = bsbo_pkg::SUM_W'(s1_sq_q[0]) + bsbo_pkg::SUM_W'(s1_sq_q[1])
        + bsbo_pkg::SUM_W'(s1_sq_q[2]);
    is_fg = sum >= bsbo_pkg::SUM_W'(thr_sq_q);
    store_pix = is_fg ? s1_pix_q : bsbo_pkg::PIX_WHITE;
  end

  assign q_push_o = s1_valid_q;
  assign q_data_o = {s1_op_q, is_fg, s1_last_q, s1_row_q, s1_col_q, store_pix};

endmodule

FILE: rtl/core/bsbo_fifo.sv
module bsbo_fifo #(
  parameter int WIDTH = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [WIDTH-1:0]            data_i,
  input  logic                        pop_i,
  output logic                        valid_o,
  output logic [WIDTH-1:0]            data_o,
  output logic [bsbo_pkg::QCNT_W-1:0] count_o
);

  localparam int PW = $clog2(bsbo_pkg::QUEUE_DEPTH);

  logic [WIDTH-1:0]            slot_q [bsbo_pkg::QUEUE_DEPTH];
  logic [PW-1:0]               wr_ptr_q, rd_ptr_q;
  logic [bsbo_pkg::QCNT_W-1:0] count_q, count_d;
  logic                        do_pop;

  assign valid_o = (count_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign data_o  = slot_q[rd_ptr_q];
  assign count_o = count_q;

  // Occupancy follows pushes and pops.
  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + bsbo_pkg::QCNT_W'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - bsbo_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/core/bsbo_back.sv
module bsbo_back #(
  parameter int MAX_SIDE = bsbo_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  logic [3+2*$clog2(MAX_SIDE)+bsbo_pkg::PIX_W-1:0] q_data_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bsbo_pkg::PIX_W-1:0]    out_pix_o,
  output logic                          out_edge_o,
  output logic                          out_last_o
);

  localparam int CW = $clog2(MAX_SIDE);
  localparam int AW = 2 * CW;

  // Fields of the queue head.
  logic                       h_op, h_fg, h_last;
  logic [CW-1:0]              h_row, h_col;
  logic [bsbo_pkg::PIX_W-1:0] h_pix;
  logic [AW-1:0]              h_addr;

  // Frame store, addressed by row and column.
  logic [bsbo_pkg::PIX_W-1:0] mem [2**AW];
  logic [bsbo_pkg::PIX_W-1:0] rdata_q;

  // Bounding box.
  logic          found_q, found_d;
  logic [CW-1:0] top_q, top_d, bot_q, bot_d, left_q, left_d, right_q, right_d;
  logic          found_eff;

  // Read stage after the store, then the output register.
  logic b_valid_q, b_edge_q, b_last_q;
  logic o_valid_q, o_edge_q, o_last_q;
  logic [bsbo_pkg::PIX_W-1:0] o_pix_q;
  logic xfer, pop, wr_en, rd_en, edge_hit, in_cols, in_rows;

  assign {h_op, h_fg, h_last, h_row, h_col, h_pix} = q_data_i;
  assign h_addr = {h_row, h_col};

  // Move the read stage into the output register when it is free or drains.
  assign xfer = b_valid_q && (!o_valid_q || out_ready_i);

  // Loads never wait; a read waits for room behind the store.
  assign pop   = q_valid_i && ((h_op == bsbo_pkg::OP_LOAD) || !b_valid_q || xfer);
  assign wr_en = pop && (h_op == bsbo_pkg::OP_LOAD);
  assign rd_en = pop && (h_op == bsbo_pkg::OP_READ);
  assign q_pop_o = pop;

  // Box edge test against the box as it stands now.
  always_comb begin
    in_cols  = (h_col >= left_q) && (h_col <= right_q);
    in_rows  = (h_row >= top_q) && (h_row <= bot_q);
    edge_hit = found_q && ((((h_row == top_q) || (h_row == bot_q)) && in_cols)
                        || (((h_col == left_q) || (h_col == right_q)) && in_rows));
  end

  // Box update; the first pixel of a frame starts a fresh box.
  always_comb begin
    found_d   = found_q;
    top_d     = top_q;
    bot_d     = bot_q;
    left_d    = left_q;
    right_d   = right_q;
    found_eff = found_q;
    if (wr_en) begin
      if ((h_row == '0) && (h_col == '0)) begin
        found_eff = 1'b0;
        found_d   = 1'b0;
        top_d     = '0;
        bot_d     = '0;
        left_d    = '0;
        right_d   = '0;
      end
      if (h_fg) begin
        found_d = 1'b1;
        if (!found_eff) begin
          top_d   = h_row;
          bot_d   = h_row;
          left_d  = h_col;
          right_d = h_col;
        end else begin
          if (h_row < top_q)   top_d   = h_row;
          if (h_row > bot_q)   bot_d   = h_row;
          if (h_col < left_q)  left_d  = h_col;
          if (h_col > right_q) right_d = h_col;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q   <= 1'b0;
      top_q     <= '0;
      bot_q     <= '0;
      left_q    <= '0;
      right_q   <= '0;
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      found_q <= found_d;
      top_q   <= top_d;
      bot_q   <= bot_d;
      left_q  <= left_d;
      right_q <= right_d;
      if (rd_en) begin
        b_valid_q <= 1'b1;
      end else if (xfer) begin
        b_valid_q <= 1'b0;
      end
      if (xfer) begin
        o_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  // Store port: one write or one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[h_addr] <= h_pix;
    end
    if (rd_en) begin
      rdata_q <= mem[h_addr];
    end
  end

  // Payload of the read stage and the output register.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      b_edge_q <= edge_hit;
      b_last_q <= h_last;
    end
    if (xfer) begin
      o_pix_q  <= b_edge_q ? bsbo_pkg::PIX_RED : rdata_q;
      o_edge_q <= b_edge_q;
      o_last_q <= b_last_q;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_pix_o   = o_pix_q;
  assign out_edge_o  = o_edge_q;
  assign out_last_o  = o_last_q;

endmodule

FILE: rtl/core/background_subtract_bbox_overlay_top.sv
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata: bg rgb, fg rgb; tuser: opcode
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: out rgb; tuser: on_box; tlast
// apb       in         psel/penable, pready high     frame_width, frame_height, threshold
//
// One item is taken per cycle as long as the output keeps draining.
// A load passes the front stage and the queue before it is written to the frame store;
// a read result reaches m_axis in order: the front stage hands it to the queue,
// the store read port takes it next, the output register last.
// Reset clears positions and the box; the frame store is not cleared.
// A stalled read holds the queue, and the front stops once the queue is full.
module background_subtract_bbox_overlay_top #(
  parameter int MAX_SIDE = bsbo_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // bg_red, bg_green, bg_blue, fg_red, fg_green, fg_blue
  input  logic [6*bsbo_pkg::CHAN_W-1:0]      s_axis_tdata,
  // opcode
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // out_red, out_green, out_blue
  output logic [bsbo_pkg::PIX_W-1:0]         m_axis_tdata,
  // on_box
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bsbo_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [bsbo_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [bsbo_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  localparam int EW = 3 + 2 * $clog2(MAX_SIDE) + bsbo_pkg::PIX_W;

  bsbo_pkg::cfg_t              cfg_q;
  logic [1:0]                  reg_idx;
  logic                        cfg_wr;
  logic                        q_push, q_pop, q_valid;
  logic [EW-1:0]               q_wdata, q_rdata;
  logic [bsbo_pkg::QCNT_W-1:0] q_count;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width        <= bsbo_pkg::RST_FRAME_WIDTH;
      cfg_q.frame_height       <= bsbo_pkg::RST_FRAME_HEIGHT;
      cfg_q.distance_threshold <= bsbo_pkg::RST_THRESHOLD;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        bsbo_pkg::REG_FRAME_WIDTH:  cfg_q.frame_width <= pwdata[bsbo_pkg::CFG_W-1:0];
        bsbo_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height <= pwdata[bsbo_pkg::CFG_W-1:0];
        bsbo_pkg::REG_THRESHOLD: begin
          cfg_q.distance_threshold <= pwdata[bsbo_pkg::CFG_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      bsbo_pkg::REG_FRAME_WIDTH:  prdata = bsbo_pkg::APB_DATA_W'(cfg_q.frame_width);
      bsbo_pkg::REG_FRAME_HEIGHT: prdata = bsbo_pkg::APB_DATA_W'(cfg_q.frame_height);
      bsbo_pkg::REG_THRESHOLD:    prdata = bsbo_pkg::APB_DATA_W'(cfg_q.distance_threshold);
      default:                    prdata = '0;
    endcase
  end

  bsbo_front #(
    .MAX_SIDE(MAX_SIDE)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .in_op_i   (s_axis_tuser),
    .in_data_i (s_axis_tdata),
    .q_count_i (q_count),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  bsbo_fifo #(
    .WIDTH(EW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_rdata),
    .count_o(q_count)
  );

  bsbo_back #(
    .MAX_SIDE(MAX_SIDE)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_pix_o  (m_axis_tdata),
    .out_edge_o (m_axis_tuser),
    .out_last_o (m_axis_tlast)
  );

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;

  localparam int SIDE = bsbo_pkg::MAX_SIDE_DEFAULT;
  localparam int RANDOM_ITEMS = 500;
  localparam int DRAIN_CYCLES = 8;
  // Index beyond the register file; writes to it must change nothing.
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t pix;
    logic on_box;
    logic last;
  } pixel_out_t;

  typedef enum logic [1:0] {ROW_LOAD, ROW_READ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  reg_idx;
    logic [8:0]  reg_val;
    rgb_t        bg;
    rgb_t        fg;
    logic        typed;
    rgb_t        want_pix;
    logic        want_box;
    logic        want_last;
  } stim_row_t;

  localparam rgb_t WHITE    = 24'hFFFFFF;
  localparam rgb_t EDGE_RED = 24'hFF0000;

  // Clock, reset and the block's inputs, all known from time zero.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_user = 1'b0;
  logic [47:0] s_data = '0;
  logic        m_ready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;

  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the block: configuration, frame store, raster positions and box.
  logic [8:0] cfg_width  = bsbo_pkg::RST_FRAME_WIDTH;
  logic [8:0] cfg_height = bsbo_pkg::RST_FRAME_HEIGHT;
  logic [8:0] cfg_thr    = bsbo_pkg::RST_THRESHOLD;
  rgb_t       pixel_mem [SIDE*SIDE];
  bit         pixel_loaded [SIDE*SIDE];
  int         load_row = 0;
  int         load_col = 0;
  int         out_row = 0;
  int         out_col = 0;
  int         box_top = 0;
  int         box_bottom = 0;
  int         box_left = 0;
  int         box_right = 0;
  bit         box_seen = 1'b0;

  pixel_out_t pending_pixels [$];
  int         mismatch_count = 0;
  int         ready_hold = 0;
  bit         calm = 1'b0;

  // Reset-time frame first, then size and threshold extremes mid-frame.
  stim_row_t directed_rows [0:25] = '{
    '{ROW_LOAD, '0, '0, 24'h000000, 24'h000000, 1'b0, '0, 1'b0, 1'b0},
    '{ROW_LOAD, '0, '0, 24'hFFFFFF, 24'h000000, 1'b0, '0, 1'b0, 1'b0},
    '{ROW_LOAD, '0, '0, 24'h646464, 24'h826464, 1'b0, '0, 1'b0, 1'b0},
    '{ROW_LOAD, '0, '0, 24'h646464, 24'h816464, 1'b0, '0, 1'b0, 1'b0},
    '{ROW_LOAD, '0, '0, 24'h000000, 24'h111111, 1'b0, '0, 1'b0, 1'b0},
    '{ROW_LOAD, '0, '0, 24'h000000, 24'h121212, 1'b0, '0, 1'b0, 1'b0},
    '{ROW_READ, '0, '0, '0, '0, 1'b1, 24'hFFFFFF, 1'b0, 1'b0},
    '{ROW_READ, '0, '0, '0, '0, 1'b1, 24'hFF0000, 1'b1, 1'b0},
    '{ROW_READ, '0, '0, '0, '0, 1'b1, 24'hFF0000, 1'b1, 1'b0},
    '{ROW_READ, '0, '0, '0, '0, 1'b1, 24'hFF0000, 1'b1, 1'b0},
    '{ROW_READ, '0, '0, '0, '0, 1'b1, 24'hFF0000, 1'b1, 1'b0},
    '{ROW_READ, '0, '0, '0, '0, 1'b1, 24'hFF0000, 1'b1, 1'b0},
    '{ROW_CFG, bsbo_pkg::REG_FRAME_WIDTH, 9'd0, '0, '0, 1'b0, '0, 1'b0, 1'b0},
    '{ROW_CFG, bsbo_pkg::REG_FRAME_HEIGHT, 9'd2, '0, '0, 1'b0, '0, 1'b0, 1'b0},
    '{ROW_CFG, bsbo_pkg::REG_THRESHOLD, 9'd0, '0, '0, 1'b0, '0, 1'b0, 1'b0},
    '{ROW_LOAD, '0, '0, 24'h5A5A5A, 24'h5A5A5A, 1'b0, '0, 1'b0, 1'b0},
    '{ROW_LOAD, '0, '0, 24'h123456, 24'h654321, 1'b0, '0, 1'b0, 1'b0},
    '{ROW_LOAD, '0, '0, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0, 1'b0, 1'b0},
    '{ROW_READ, '0, '0, '0, '0, 1'b0, '0, 1'b0, 1'b0},
    '{ROW_READ, '0, '0, '0, '0, 1'b0, '0, 1'b0, 1'b0},
    '{ROW_READ, '0, '0, '0, '0, 1'b0, '0, 1'b0, 1'b0},
    '{ROW_CFG, bsbo_pkg::REG_THRESHOLD, 9'd442, '0, '0, 1'b0, '0, 1'b0, 1'b0},
    '{ROW_CFG, bsbo_pkg::REG_FRAME_WIDTH, 9'd511, '0, '0, 1'b0, '0, 1'b0, 1'b0},
    '{ROW_CFG, REG_SPARE, 9'd7, '0, '0, 1'b0, '0, 1'b0, 1'b0},
    '{ROW_LOAD, '0, '0, 24'h000000, 24'hFFFFFF, 1'b0, '0, 1'b0, 1'b0},
    '{ROW_READ, '0, '0, '0, '0, 1'b0, '0, 1'b0, 1'b0}
  };

  background_subtract_bbox_overlay_top #(
    .MAX_SIDE(SIDE)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #3000000;
    $display("FAIL background_subtract_bbox_overlay_top");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Idle cycles before the next item or result; none during calm phases.
  function automatic int draw_wait();
    return calm ? 0 : int'($urandom_range(0, 5));
  endfunction

  function automatic int side_of(input logic [8:0] v);
    if (v == 9'd0) return 1;
    if (v > SIDE) return SIDE;
    return int'(v);
  endfunction

  function automatic int sq_diff(input logic [7:0] a, input logic [7:0] b);
    int d;
    d = int'(a) - int'(b);
    return d * d;
  endfunction

  // Moves a channel by a random amount in either direction, clipped to 0..255.
  function automatic logic [7:0] nudge(input logic [7:0] c, input int spread);
    int v;
    v = int'(c) + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, spread));
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // Raster step that wraps once the column or row reaches the current bound.
  task automatic step_raster(inout int row, inout int col);
    col = col + 1;
    if (col >= side_of(cfg_width)) begin
      col = 0;
      row = row + 1;
      if (row >= side_of(cfg_height)) row = 0;
    end
  endtask

  // Applies one item to the shadow state; a read yields the expected pixel.
  task automatic model_item(input logic op, input rgb_t bg, input rgb_t fg,
                            output bit has_out, output pixel_out_t res);
    int row;
    int col;
    int addr;
    int sum;
    int thr;
    bit edge_hit;
    res = '0;
    if (op == bsbo_pkg::OP_LOAD) begin
      row = load_row;
      col = load_col;
      addr = row * SIDE + col;
      sum = sq_diff(bg.red, fg.red) + sq_diff(bg.green, fg.green)
          + sq_diff(bg.blue, fg.blue);
      thr = int'(cfg_thr);
      // The first pixel of a frame starts a fresh box.
      if (row == 0 && col == 0) begin
        box_seen = 1'b0;
        box_top = 0;
        box_bottom = 0;
        box_left = 0;
        box_right = 0;
      end
      if (sum >= thr * thr) begin
        pixel_mem[addr] = fg;
        if (!box_seen) begin
          box_seen = 1'b1;
          box_top = row;
          box_bottom = row;
          box_left = col;
          box_right = col;
        end else begin
          if (row < box_top) box_top = row;
          if (row > box_bottom) box_bottom = row;
          if (col < box_left) box_left = col;
          if (col > box_right) box_right = col;
        end
      end else begin
        pixel_mem[addr] = WHITE;
      end
      pixel_loaded[addr] = 1'b1;
      step_raster(load_row, load_col);
      has_out = 1'b0;
    end else begin
      row = out_row;
      col = out_col;
      addr = row * SIDE + col;
      edge_hit = box_seen &&
        (((row == box_top || row == box_bottom) && col >= box_left && col <= box_right) ||
         ((col == box_left || col == box_right) && row >= box_top && row <= box_bottom));
      res.pix = edge_hit ? EDGE_RED : pixel_mem[addr];
      res.on_box = edge_hit;
      res.last = (row == side_of(cfg_height) - 1) && (col == side_of(cfg_width) - 1);
      step_raster(out_row, out_col);
      has_out = 1'b1;
    end
  endtask

  // Offers one item, waits for it to be taken and records what it should produce.
  task automatic send_item(input logic op, input rgb_t bg, input rgb_t fg,
                           input bit typed, input pixel_out_t want);
    int gap;
    bit has_out;
    pixel_out_t predicted;
    gap = draw_wait();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= {fg.blue, fg.green, fg.red, bg.blue, bg.green, bg.red};
    @(posedge clk);
    while (s_axis_tready !== 1'b1) @(posedge clk);
    model_item(op, bg, fg, has_out, predicted);
    if (has_out) pending_pixels.insert(pending_pixels.size(), typed ? want : predicted);
  endtask

  // Stops the stream and waits until every read has come back and loads have landed.
  task automatic settle();
    s_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write followed by a read back of the same register, except for the spare index.
  task automatic cfg_write(input logic [1:0] idx, input logic [8:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      bsbo_pkg::REG_FRAME_WIDTH:  cfg_width = value;
      bsbo_pkg::REG_FRAME_HEIGHT: cfg_height = value;
      bsbo_pkg::REG_THRESHOLD:    cfg_thr = value;
      default: ;
    endcase
    if (idx != REG_SPARE) begin
      @(posedge clk);
      psel   <= 1'b1;
      pwrite <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      @(negedge clk);
      if (prdata !== 32'(value))
        report_mismatch($sformatf("register %0d reads %0h, wrote %0h", idx, prdata, value));
      @(posedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
    @(posedge clk);
  endtask

  // Result receiver: after each item taken it holds tready low for a random spell, none in calm phases.
  always @(posedge clk) begin
    if (m_axis_tvalid === 1'b1 && m_ready) ready_hold = draw_wait();
    else if (ready_hold > 0) ready_hold--;
    m_ready <= (ready_hold == 0);
  end

  // Compares each returned pixel with the oldest outstanding read.
  always @(posedge clk) begin
    pixel_out_t want;
    if (rst_n && m_axis_tvalid === 1'b1 && m_ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("pixel returned with no read outstanding");
      end else begin
        want = pending_pixels.pop_front();
        if (m_axis_tdata[7:0] !== want.pix.red)
          report_mismatch($sformatf("red %0h, want %0h", m_axis_tdata[7:0], want.pix.red));
        if (m_axis_tdata[15:8] !== want.pix.green)
          report_mismatch($sformatf("green %0h, want %0h", m_axis_tdata[15:8],
                                    want.pix.green));
        if (m_axis_tdata[23:16] !== want.pix.blue)
          report_mismatch($sformatf("blue %0h, want %0h", m_axis_tdata[23:16],
                                    want.pix.blue));
        if (m_axis_tuser !== want.on_box)
          report_mismatch($sformatf("on_box %b, want %b", m_axis_tuser, want.on_box));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("is_last %b, want %b", m_axis_tlast, want.last));
      end
    end
  end

  // Reset, directed table, then random phases with fresh settings each time.
  initial begin : stimulus
    stim_row_t  entry;
    rgb_t       bg;
    rgb_t       fg;
    logic [8:0] new_w;
    logic [8:0] new_h;
    logic [8:0] new_t;
    int         random_items;
    int         phase_len;
    random_items = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      entry = directed_rows[i];
      case (entry.kind)
        ROW_CFG: begin
          settle();
          cfg_write(entry.reg_idx, entry.reg_val);
        end
        ROW_LOAD: send_item(bsbo_pkg::OP_LOAD, entry.bg, entry.fg, 1'b0, '0);
        default: send_item(bsbo_pkg::OP_READ, entry.bg, entry.fg, entry.typed,
                           {entry.want_pix, entry.want_box, entry.want_last});
      endcase
    end

    while (random_items < RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 9))
        0: new_w = 9'd0;
        1: new_w = 9'($urandom_range(256, 511));
        2: new_w = 9'd1;
        default: new_w = 9'($urandom_range(2, 12));
      endcase
      // Wide rows only with very few of them, so frames stay short.
      if (side_of(new_w) > 16) begin
        new_h = 9'($urandom_range(0, 2));
      end else begin
        case ($urandom_range(0, 9))
          0: new_h = 9'd0;
          1: new_h = 9'($urandom_range(256, 511));
          default: new_h = 9'($urandom_range(1, 8));
        endcase
      end
      case ($urandom_range(0, 9))
        0: new_t = 9'd0;
        1: new_t = 9'd442;
        2: new_t = 9'($urandom_range(443, 511));
        default: new_t = 9'($urandom_range(1, 120));
      endcase
      cfg_write(bsbo_pkg::REG_FRAME_WIDTH, new_w);
      cfg_write(bsbo_pkg::REG_FRAME_HEIGHT, new_h);
      cfg_write(bsbo_pkg::REG_THRESHOLD, new_t);
      calm = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(30, 70);

      repeat (phase_len) begin
        bg = rgb_t'($urandom);
        fg = rgb_t'($urandom);
        // A read may only go to a pixel that has been loaded since reset.
        if (pixel_loaded[out_row * SIDE + out_col] && $urandom_range(0, 1)) begin
          send_item(bsbo_pkg::OP_READ, bg, fg, 1'b0, '0);
        end else begin
          case ($urandom_range(0, 4))
            0: fg = bg;
            1, 2: begin
              fg.red   = nudge(bg.red, int'(cfg_thr));
              fg.green = nudge(bg.green, int'(cfg_thr));
              fg.blue  = nudge(bg.blue, int'(cfg_thr));
            end
            3: ;
            default: begin
              bg = $urandom_range(0, 1) ? 24'h000000 : 24'hFFFFFF;
              fg = ~bg;
            end
          endcase
          send_item(bsbo_pkg::OP_LOAD, bg, fg, 1'b0, '0);
        end
      end
      random_items += phase_len;
    end

    settle();
    if (mismatch_count == 0) begin
      $display("PASS background_subtract_bbox_overlay_top");
    end else begin
      $display("FAIL background_subtract_bbox_overlay_top");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/bsbo_pkg.sv
rtl/core/bsbo_front.sv
rtl/core/bsbo_fifo.sv
rtl/core/bsbo_back.sv
rtl/core/background_subtract_bbox_overlay_top.sv
tb/sv/tb_top.sv
